/* rtl/ifst_pkg.sv */
// shared types, constants and the byte stuffing function for the info frame transmitter
// no dependencies

package ifst_pkg;

   localparam int BYTE_W     = 8;
   localparam int SLOT_COUNT = 9;
   localparam int CSR_IDX_W  = 3;

   // fixed slot positions inside one expanded run
   localparam int SLOT_FLAG_OPEN = 0;
   localparam int SLOT_ADDR      = 1;
   localparam int SLOT_CTRL      = 2;
   localparam int SLOT_BCC1      = 3;
   localparam int SLOT_DATA_A    = 4;
   localparam int SLOT_DATA_B    = 5;
   localparam int SLOT_BCC2_A    = 6;
   localparam int SLOT_BCC2_B    = 7;
   localparam int SLOT_CLOSE     = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FLAG      = 3'd0,
      CSR_ESCAPE    = 3'd1,
      CSR_FLAG_SUB  = 3'd2,
      CSR_ESC_SUB   = 3'd3,
      CSR_ADDRESS   = 3'd4,
      CSR_CTRL_BASE = 3'd5,
      CSR_SEQ_MASK  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] payload_byte;
      logic              final_byte;
   } req_word_type;

   typedef struct packed {
      logic [BYTE_W-1:0] line_byte;
      logic              run_end;
      logic              frame_end;
   } rsp_word_type;

   typedef struct packed {
      logic [BYTE_W-1:0] flag_byte;
      logic [BYTE_W-1:0] escape_byte;
      logic [BYTE_W-1:0] flag_substitute;
      logic [BYTE_W-1:0] escape_substitute;
      logic [BYTE_W-1:0] frame_address;
      logic [BYTE_W-1:0] info_control_base;
      logic [BYTE_W-1:0] sequence_mask;
   } cfg_type;

   typedef struct packed {
      logic              next_sequence;
      logic              inside_frame;
      logic [BYTE_W-1:0] running_check;
   } frame_state_type;

   typedef struct packed {
      logic [SLOT_COUNT-1:0]             mask;
      logic [SLOT_COUNT-1:0][BYTE_W-1:0] bytes;
   } frame_run_type;

   typedef struct packed {
      logic              two;
      logic [BYTE_W-1:0] first;
      logic [BYTE_W-1:0] second;
   } stuffed_type;

   localparam logic [BYTE_W-1:0] RST_FLAG      = 8'd126;
   localparam logic [BYTE_W-1:0] RST_ESCAPE    = 8'd125;
   localparam logic [BYTE_W-1:0] RST_FLAG_SUB  = 8'd94;
   localparam logic [BYTE_W-1:0] RST_ESC_SUB   = 8'd93;
   localparam logic [BYTE_W-1:0] RST_ADDRESS   = 8'd3;
   localparam logic [BYTE_W-1:0] RST_CTRL_BASE = 8'd0;
   localparam logic [BYTE_W-1:0] RST_SEQ_MASK  = 8'd64;

   // flag match wins over escape match when both are equal
   function automatic stuffed_type stuff_byte(input logic [BYTE_W-1:0] b, input cfg_type cfg);
      stuffed_type s;
      s.two    = 1'b0;
      s.first  = b;
      s.second = b;
      if (b == cfg.flag_byte) begin
         s.two    = 1'b1;
         s.first  = cfg.escape_byte;
         s.second = cfg.flag_substitute;
      end else if (b == cfg.escape_byte) begin
         s.two    = 1'b1;
         s.first  = cfg.escape_byte;
         s.second = cfg.escape_substitute;
      end
      return s;
   endfunction

endpackage

/* rtl/ifst_expand.sv */
// expands one payload word into a fixed-slot run of line bytes plus the next frame state
// depends on ifst_pkg

module ifst_expand (
   input  ifst_pkg::req_word_type    word,
   input  ifst_pkg::cfg_type         cfg,
   input  ifst_pkg::frame_state_type state,
   output ifst_pkg::frame_run_type   run,
   output ifst_pkg::frame_state_type state_next
);

   logic                          header;
   logic [ifst_pkg::BYTE_W-1:0]   ctrl;
   logic [ifst_pkg::BYTE_W-1:0]   check;
   ifst_pkg::stuffed_type         data_st;
   ifst_pkg::stuffed_type         bcc_st;

   always_comb begin
      header  = !state.inside_frame;
      ctrl    = cfg.info_control_base |
                (state.next_sequence ? cfg.sequence_mask : '0);
      check   = (header ? '0 : state.running_check) ^ word.payload_byte;
      data_st = ifst_pkg::stuff_byte(word.payload_byte, cfg);
      bcc_st  = ifst_pkg::stuff_byte(check, cfg);

      run.bytes[ifst_pkg::SLOT_FLAG_OPEN] = cfg.flag_byte;
      run.bytes[ifst_pkg::SLOT_ADDR]      = cfg.frame_address;
      run.bytes[ifst_pkg::SLOT_CTRL]      = ctrl;
      run.bytes[ifst_pkg::SLOT_BCC1]      = cfg.frame_address ^ ctrl;
      run.bytes[ifst_pkg::SLOT_DATA_A]    = data_st.first;
      run.bytes[ifst_pkg::SLOT_DATA_B]    = data_st.second;
      run.bytes[ifst_pkg::SLOT_BCC2_A]    = bcc_st.first;
      run.bytes[ifst_pkg::SLOT_BCC2_B]    = bcc_st.second;
      run.bytes[ifst_pkg::SLOT_CLOSE]     = cfg.flag_byte;

      run.mask[ifst_pkg::SLOT_FLAG_OPEN] = header;
      run.mask[ifst_pkg::SLOT_ADDR]      = header;
      run.mask[ifst_pkg::SLOT_CTRL]      = header;
      run.mask[ifst_pkg::SLOT_BCC1]      = header;
      run.mask[ifst_pkg::SLOT_DATA_A]    = 1'b1;
      run.mask[ifst_pkg::SLOT_DATA_B]    = data_st.two;
      run.mask[ifst_pkg::SLOT_BCC2_A]    = word.final_byte;
      run.mask[ifst_pkg::SLOT_BCC2_B]    = word.final_byte & bcc_st.two;
      run.mask[ifst_pkg::SLOT_CLOSE]     = word.final_byte;

      state_next.next_sequence = header ? !state.next_sequence : state.next_sequence;
      state_next.inside_frame  = !word.final_byte;
      state_next.running_check = word.final_byte ? '0 : check;
   end

endmodule

/* rtl/ifst_serial.sv */
// holds one expanded run and sends its enabled slots one line byte per cycle while rsp_ready does not stall it
// depends on ifst_pkg

module ifst_serial (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    run_valid,
   output logic                    run_ready,
   input  ifst_pkg::frame_run_type run,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output ifst_pkg::rsp_word_type  rsp_word
);

   logic [ifst_pkg::SLOT_COUNT-1:0]                   mask_ff, mask_in;
   logic [ifst_pkg::SLOT_COUNT-1:0][ifst_pkg::BYTE_W-1:0] bytes_ff, bytes_in;
   logic                    out_valid_ff, out_valid_in;
   ifst_pkg::rsp_word_type  out_word_ff, out_word_in;

   logic                              pop;
   logic [ifst_pkg::SLOT_COUNT-1:0]   lowest;
   logic [ifst_pkg::SLOT_COUNT-1:0]   rest;
   logic [ifst_pkg::SLOT_COUNT-1:0]   mask_after;
   logic [ifst_pkg::BYTE_W-1:0]       pick;
   logic                              load;

   always_comb begin
      pop        = (mask_ff != '0) && (!out_valid_ff || rsp_ready);
      lowest     = mask_ff & (~mask_ff + 1'b1);
      rest       = mask_ff & ~lowest;
      mask_after = pop ? rest : mask_ff;
      run_ready  = (mask_after == '0);
      load       = run_valid && run_ready;

      // one-hot select of the lowest pending slot
      pick = '0;
      for (int i = 0; i < ifst_pkg::SLOT_COUNT; i++) begin
         pick = pick | (lowest[i] ? bytes_ff[i] : '0);
      end

      mask_in  = load ? run.mask : mask_after;
      bytes_in = load ? run.bytes : bytes_ff;

      out_valid_in = pop ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
      out_word_in  = out_word_ff;
      if (pop) begin
         out_word_in.line_byte = pick;
         out_word_in.run_end   = (rest == '0);
         out_word_in.frame_end = lowest[ifst_pkg::SLOT_CLOSE];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff    <= bytes_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule

/* rtl/info_frame_stuffing_transmitter_core.sv */
// top level of the info frame stuffing transmitter: csr bank, frame state, expander, serializer
// depends on ifst_pkg, ifst_expand and ifst_serial

// Each accepted payload word is expanded in one pass into up to nine line bytes:
// on the first word of a frame the header (flag, address, control, BCC1), then
// the stuffed payload byte, and on the word marked final the stuffed BCC2 and
// the closing flag. The serializer sends one line byte per cycle while the output
// is not stalled. A word produces 1 or 2 line bytes in mid-frame, 5 or 6 for
// the opening word of a longer frame, 3 to 5 for the closing word, up to 9
// for a single-byte frame. The next word is taken in the same cycle the last
// line byte of the previous word moves to the output register, so a stream of
// payload words with no stuffing runs at one word per cycle while not stalled. The sequence bit
// starts at 0 after reset and flips on every new frame. CSRs are write-only
// and should be changed only while no frame traffic is pending.

module info_frame_stuffing_transmitter_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  ifst_pkg::req_word_type            req_word,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output ifst_pkg::rsp_word_type            rsp_word,
   input  logic                              csr_write_enable,
   input  logic [ifst_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ifst_pkg::BYTE_W-1:0]       csr_write_data
);

   // csr bank
   ifst_pkg::cfg_type cfg_ff, cfg_in;

   // frame state: sequence bit, open frame, running BCC2
   ifst_pkg::frame_state_type state_ff, state_in;
   ifst_pkg::frame_state_type state_next;

   ifst_pkg::frame_run_type run;
   logic                    accept;

   // csr write decode, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (ifst_pkg::csr_index_type'(csr_index))
            ifst_pkg::CSR_FLAG:      cfg_in.flag_byte         = csr_write_data;
            ifst_pkg::CSR_ESCAPE:    cfg_in.escape_byte       = csr_write_data;
            ifst_pkg::CSR_FLAG_SUB:  cfg_in.flag_substitute   = csr_write_data;
            ifst_pkg::CSR_ESC_SUB:   cfg_in.escape_substitute = csr_write_data;
            ifst_pkg::CSR_ADDRESS:   cfg_in.frame_address     = csr_write_data;
            ifst_pkg::CSR_CTRL_BASE: cfg_in.info_control_base = csr_write_data;
            ifst_pkg::CSR_SEQ_MASK:  cfg_in.sequence_mask     = csr_write_data;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flag_byte         <= ifst_pkg::RST_FLAG;
         cfg_ff.escape_byte       <= ifst_pkg::RST_ESCAPE;
         cfg_ff.flag_substitute   <= ifst_pkg::RST_FLAG_SUB;
         cfg_ff.escape_substitute <= ifst_pkg::RST_ESC_SUB;
         cfg_ff.frame_address     <= ifst_pkg::RST_ADDRESS;
         cfg_ff.info_control_base <= ifst_pkg::RST_CTRL_BASE;
         cfg_ff.sequence_mask     <= ifst_pkg::RST_SEQ_MASK;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // expand the incoming word against the current frame state
   ifst_expand u_expand (
      .word       (req_word),
      .cfg        (cfg_ff),
      .state      (state_ff),
      .run        (run),
      .state_next (state_next)
   );

   // state advances only when a word is taken
   assign accept   = req_valid && req_ready;
   assign state_in = accept ? state_next : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   // run buffer and output register
   ifst_serial u_serial (
      .clock     (clock),
      .reset     (reset),
      .run_valid (req_valid),
      .run_ready (req_ready),
      .run       (run),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule
